// ===== rtl/core/tmk_pkg.sv =====
// Shared constants and codes for the trie multi-keyword matcher.
// No dependencies.
package tmk_pkg;

    localparam int STATES_DEF      = 256;
    localparam int MAX_KEY_LEN_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int TAG_W   = 16;
    localparam int START_W = 32;
    localparam int MLEN_W  = 6;
    localparam int ERR_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_KEYWORD = 2'd1,
        CMD_TEXT    = 2'd2,
        CMD_EOT     = 2'd3
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_TABLE_FULL = 2'd1,
        ERR_TOO_LONG  = 2'd2,
        ERR_RSVD      = 2'd3
    } err_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SWEEP = 8'b0000_0010,
        ST_KEY   = 8'b0000_0100,
        ST_FETCH = 8'b0000_1000,
        ST_LOOK  = 8'b0001_0000,
        ST_EVAL  = 8'b0010_0000,
        ST_FLUSH = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

// ===== rtl/core/trie_multi_keyword_matcher_top.sv =====
// Trie multi-keyword matcher: transition table memory, text lookback buffer
// and the build / scan sequencer. Depends on tmk_pkg.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_command s_data_byte s_keyword_end s_keyword_tag
//  m_      | out       | m_valid m_ready m_match_valid m_match_start m_match_length
//          |           | m_match_tag m_error_code m_last
//
// Keyword byte: accept and table read, write back, result; no write back when discarded
// or too long. Text byte: accept and read, evaluate, result, plus fetch, look, evaluate
// per buffered byte replayed after a dead end. End of text: flush per attempt, replays,
// result. Clear table, reset: STATES*256-cell sweep, one per cycle, no transaction taken.
// One result register holds back the prior result so last can be marked; the sequencer
// stalls when it must emit with both result registers full, or ends with the output full.
module trie_multi_keyword_matcher_top
    import tmk_pkg::*;
#(
    parameter int STATES      = STATES_DEF,
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_command,
    input  logic [BYTE_W-1:0]  s_data_byte,
    input  logic               s_keyword_end,
    input  logic [TAG_W-1:0]   s_keyword_tag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_match_valid,
    output logic [START_W-1:0] m_match_start,
    output logic [MLEN_W-1:0]  m_match_length,
    output logic [TAG_W-1:0]   m_match_tag,
    output logic [ERR_W-1:0]   m_error_code,
    output logic               m_last
);

    localparam int NW        = $clog2(STATES);
    localparam int AW        = NW + BYTE_W;
    localparam int TBL_DEPTH = STATES * 256;
    localparam int CW        = $clog2(MAX_KEY_LEN + 2);
    localparam int LW        = $clog2(MAX_KEY_LEN + 1);
    localparam int BW        = $clog2(MAX_KEY_LEN + 1);
    localparam int BUF_DEPTH = 1 << BW;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             end_mark;
        logic [NW-1:0]    next;
    } cell_t;

    typedef struct packed {
        logic               valid;
        logic [START_W-1:0] start;
        logic [CW-1:0]      len;
        logic [TAG_W-1:0]   tag;
        err_t               err;
    } res_t;

    cell_t tbl_mem [TBL_DEPTH];
    logic [BYTE_W-1:0] buf_mem [BUF_DEPTH];

    cell_t             tbl_rd_reg;
    logic [AW-1:0]     tbl_rd_addr_reg;
    logic [BYTE_W-1:0] buf_rd_reg;
    logic              tbl_we;
    logic [AW-1:0]     tbl_waddr, tbl_raddr;
    cell_t             tbl_wdata;
    logic              buf_we;
    logic [BW-1:0]     buf_waddr, buf_raddr;

    state_t            state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic              reply_reg, reply_next;
    logic [NW-1:0]     used_reg, used_next;
    logic [NW-1:0]     bnode_reg, bnode_next;
    logic [LW-1:0]     blen_reg, blen_next;
    logic              bdisc_reg, bdisc_next;
    logic              kend_reg, kend_next;
    logic [TAG_W-1:0]  ktag_reg, ktag_next;
    logic [NW-1:0]     snode_reg, snode_next;
    logic [START_W-1:0] sstart_reg, sstart_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     plen_reg, plen_next;
    logic [TAG_W-1:0]  ptag_reg, ptag_next;
    logic [CW-1:0]     walked_reg, walked_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [BW-1:0]     head_reg, head_next;
    logic              flush_reg, flush_next;
    logic              hv_reg, hv_next;
    res_t              h_reg, h_next;
    logic              mv_reg, mv_next;
    res_t              m_reg, m_next;
    logic              mlast_reg, mlast_next;

    logic              o_free;
    logic              emit_v;
    res_t              emit_r;
    logic [CW-1:0]     len;
    logic [CW-1:0]     drop;
    logic              eff_pend;
    logic [CW-1:0]     eff_plen;
    logic [TAG_W-1:0]  eff_ptag;
    cell_t             rd_cell;

    assign o_free    = !mv_reg || m_ready;
    assign rd_cell   = tbl_rd_reg;
    assign len       = walked_reg + CW'(1);
    assign buf_raddr = head_reg + BW'(walked_reg);
    assign buf_waddr = head_reg + BW'(cnt_reg);

    always_comb begin
        eff_pend = pend_reg;
        eff_plen = plen_reg;
        eff_ptag = ptag_reg;
        if (state_reg == ST_EVAL && rd_cell.end_mark) begin
            eff_pend = 1'b1;
            eff_plen = len;
            eff_ptag = rd_cell.tag;
        end
        drop = eff_pend ? eff_plen : CW'(1);
        emit_v = 1'b0;
        emit_r = '{valid: 1'b1, start: sstart_reg, len: eff_plen, tag: eff_ptag,
                   err: ERR_NONE};
        if (state_reg == ST_EVAL) begin
            if (rd_cell.end_mark && rd_cell.next == '0) begin
                emit_v     = 1'b1;
                emit_r.len = len;
                emit_r.tag = rd_cell.tag;
            end else if (!(rd_cell.next != '0 && walked_reg < CW'(MAX_KEY_LEN))) begin
                emit_v = eff_pend;
            end
        end else if (state_reg == ST_FLUSH) begin
            emit_v = pend_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        reply_next  = reply_reg;
        used_next   = used_reg;
        bnode_next  = bnode_reg;
        blen_next   = blen_reg;
        bdisc_next  = bdisc_reg;
        kend_next   = kend_reg;
        ktag_next   = ktag_reg;
        snode_next  = snode_reg;
        sstart_next = sstart_reg;
        pend_next   = pend_reg;
        plen_next   = plen_reg;
        ptag_next   = ptag_reg;
        walked_next = walked_reg;
        cnt_next    = cnt_reg;
        head_next   = head_reg;
        flush_next  = flush_reg;
        hv_next     = hv_reg;
        h_next      = h_reg;
        mv_next     = mv_reg && !m_ready;
        m_next      = m_reg;
        mlast_next  = mlast_reg;
        tbl_we      = 1'b0;
        tbl_waddr   = {bnode_reg, s_data_byte};
        tbl_wdata   = '0;
        buf_we      = 1'b0;
        s_ready     = (state_reg == ST_IDLE);
        tbl_raddr   = (state_reg == ST_LOOK) ? {snode_reg, buf_rd_reg}
                    : (state_reg == ST_EVAL) ? tbl_rd_addr_reg
                    : (cmd_t'(s_command) == CMD_KEYWORD) ? {bnode_reg, s_data_byte}
                    : {snode_reg, s_data_byte};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (cmd_t'(s_command))
                        CMD_CLEAR: begin
                            used_next   = '0;
                            bnode_next  = '0;
                            blen_next   = '0;
                            bdisc_next  = 1'b0;
                            snode_next  = '0;
                            sstart_next = '0;
                            pend_next   = 1'b0;
                            plen_next   = '0;
                            ptag_next   = '0;
                            walked_next = '0;
                            cnt_next    = '0;
                            head_next   = '0;
                            sweep_next  = '0;
                            reply_next  = 1'b1;
                            state_next  = ST_SWEEP;
                        end
                        CMD_KEYWORD: begin
                            h_next = '{valid: 1'b0, start: '0, len: '0, tag: '0,
                                       err: ERR_NONE};
                            if (bdisc_reg) begin
                                if (s_keyword_end) begin
                                    bdisc_next = 1'b0;
                                end
                                hv_next    = 1'b1;
                                state_next = ST_DONE;
                            end else if (blen_reg >= LW'(MAX_KEY_LEN)) begin
                                h_next.err = ERR_TOO_LONG;
                                bnode_next = '0;
                                blen_next  = '0;
                                bdisc_next = !s_keyword_end;
                                hv_next    = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                kend_next  = s_keyword_end;
                                ktag_next  = s_keyword_tag;
                                state_next = ST_KEY;
                            end
                        end
                        CMD_TEXT: begin
                            buf_we     = 1'b1;
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = ST_EVAL;
                        end
                        CMD_EOT: begin
                            flush_next = 1'b1;
                            state_next = ST_FLUSH;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP: begin
                tbl_we     = 1'b1;
                tbl_waddr  = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(TBL_DEPTH - 1)) begin
                    state_next = reply_reg ? ST_DONE : ST_IDLE;
                    reply_next = 1'b0;
                end
            end
            ST_KEY: begin
                tbl_waddr = tbl_rd_addr_reg;
                h_next = '{valid: 1'b0, start: '0, len: '0, tag: '0, err: ERR_NONE};
                hv_next    = 1'b1;
                state_next = ST_DONE;
                if (kend_reg) begin
                    tbl_we     = 1'b1;
                    tbl_wdata  = '{tag: ktag_reg, end_mark: 1'b1, next: rd_cell.next};
                    bnode_next = '0;
                    blen_next  = '0;
                end else if (rd_cell.next != '0) begin
                    bnode_next = rd_cell.next;
                    blen_next  = blen_reg + LW'(1);
                end else if (used_reg == NW'(STATES - 1)) begin
                    h_next.err = ERR_TABLE_FULL;
                    bnode_next = '0;
                    blen_next  = '0;
                    bdisc_next = 1'b1;
                end else begin
                    tbl_we     = 1'b1;
                    tbl_wdata  = '{tag: rd_cell.tag, end_mark: rd_cell.end_mark,
                                  next: used_reg + NW'(1)};
                    used_next  = used_reg + NW'(1);
                    bnode_next = used_reg + NW'(1);
                    blen_next  = blen_reg + LW'(1);
                end
            end
            ST_FETCH: begin
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                state_next = ST_EVAL;
            end
            ST_EVAL, ST_FLUSH: begin
                if (!(emit_v && hv_reg && !o_free)) begin
                    if (emit_v) begin
                        if (hv_reg) begin
                            mv_next    = 1'b1;
                            m_next     = h_reg;
                            mlast_next = 1'b0;
                        end
                        hv_next = 1'b1;
                        h_next  = emit_r;
                    end
                    if (state_reg == ST_EVAL && rd_cell.end_mark && rd_cell.next == '0) begin
                        sstart_next = sstart_reg + START_W'(len);
                        head_next   = head_reg + BW'(len);
                        cnt_next    = cnt_reg - len;
                        walked_next = '0;
                        snode_next  = '0;
                        pend_next   = 1'b0;
                    end else if (state_reg == ST_EVAL && rd_cell.next != '0
                                 && walked_reg < CW'(MAX_KEY_LEN)) begin
                        walked_next = len;
                        snode_next  = rd_cell.next;
                        pend_next   = eff_pend;
                        plen_next   = eff_plen;
                        ptag_next   = eff_ptag;
                    end else if (state_reg == ST_EVAL || walked_reg != '0 || pend_reg) begin
                        sstart_next = sstart_reg + START_W'(drop);
                        head_next   = head_reg + BW'(drop);
                        cnt_next    = cnt_reg - drop;
                        walked_next = '0;
                        snode_next  = '0;
                        pend_next   = 1'b0;
                    end
                    if (state_reg == ST_FLUSH && walked_reg == '0 && !pend_reg) begin
                        sstart_next = '0;
                        cnt_next    = '0;
                        head_next   = '0;
                        state_next  = ST_DONE;
                    end else if (walked_next < cnt_next) begin
                        state_next = ST_FETCH;
                    end else begin
                        state_next = flush_reg ? ST_FLUSH : ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (o_free) begin
                    mv_next    = 1'b1;
                    mlast_next = 1'b1;
                    m_next     = hv_reg ? h_reg
                               : '{valid: 1'b0, start: '0, len: '0, tag: '0, err: ERR_NONE};
                    hv_next    = 1'b0;
                    flush_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_reg      <= tbl_mem[tbl_raddr];
        tbl_rd_addr_reg <= tbl_raddr;
        if (buf_we) begin
            buf_mem[buf_waddr] <= s_data_byte;
        end
        buf_rd_reg <= buf_mem[buf_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SWEEP;
            sweep_reg  <= '0;
            reply_reg  <= 1'b0;
            used_reg   <= '0;
            bnode_reg  <= '0;
            blen_reg   <= '0;
            bdisc_reg  <= 1'b0;
            snode_reg  <= '0;
            sstart_reg <= '0;
            pend_reg   <= 1'b0;
            plen_reg   <= '0;
            ptag_reg   <= '0;
            walked_reg <= '0;
            cnt_reg    <= '0;
            head_reg   <= '0;
            flush_reg  <= 1'b0;
            hv_reg     <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            reply_reg  <= reply_next;
            used_reg   <= used_next;
            bnode_reg  <= bnode_next;
            blen_reg   <= blen_next;
            bdisc_reg  <= bdisc_next;
            snode_reg  <= snode_next;
            sstart_reg <= sstart_next;
            pend_reg   <= pend_next;
            plen_reg   <= plen_next;
            ptag_reg   <= ptag_next;
            walked_reg <= walked_next;
            cnt_reg    <= cnt_next;
            head_reg   <= head_next;
            flush_reg  <= flush_next;
            hv_reg     <= hv_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        kend_reg  <= kend_next;
        ktag_reg  <= ktag_next;
        h_reg     <= h_next;
        m_reg     <= m_next;
        mlast_reg <= mlast_next;
    end

    assign m_valid        = mv_reg;
    assign m_match_valid  = m_reg.valid;
    assign m_match_start  = m_reg.start;
    assign m_match_length = MLEN_W'(m_reg.len);
    assign m_match_tag    = m_reg.tag;
    assign m_error_code   = m_reg.err;
    assign m_last         = mlast_reg;

endmodule
